// ===== design/rc4_pkg.sv =====
// rc4_pkg: shared widths, key reset values, controller states and the
// command and status structs between the rc4 controller and datapath.
// No dependencies.
package rc4_pkg;

  localparam int unsigned DataW      = 8;
  localparam int unsigned AddrW      = 8;
  localparam int unsigned TableDepth = 256;
  localparam int unsigned KeyWordW   = 32;
  localparam int unsigned KeyWords   = 4;
  localparam int unsigned CfgIdxW    = 2;

  // key bytes 0..15, byte 0 in the low bits of word 0
  localparam logic [KeyWordW-1:0] KeyReset [KeyWords] = '{
    32'h0403_0201, 32'h0807_0605, 32'hFCFD_FEFF, 32'hACAD_AEAF
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KS_INIT,
    ST_KS_RDN,
    ST_KS_RDJ,
    ST_KS_WRN,
    ST_KS_WRJ,
    ST_GEN_RI,
    ST_GEN_RJ,
    ST_GEN_WI,
    ST_GEN_WJ
  } rc4_state_t;

  typedef struct packed {
    logic latch_in;   // capture the input byte
    logic rd_next_i;  // i = i + 1, read S[i]
    logic init_wr;    // S[cnt] = cnt
    logic ks_rdn;     // read S[cnt]
    logic ks_rdj;     // j = j + S[cnt] + key, read S[j]
    logic ks_wrn;     // S[cnt] = old S[j]
    logic ks_wrj;     // S[j] = old S[cnt], read S[cnt+1]
    logic gen_rj;     // j = j + S[i], read S[j]
    logic gen_wi;     // S[i] = old S[j], read S[t]
    logic gen_wj;     // S[j] = old S[i]
    logic out_load;   // load the result register
  } rc4_cmd_t;

  typedef struct packed {
    logic cnt_last;   // sweep counter at the last table entry
    logic out_free;   // result register can take a new byte
  } rc4_stat_t;

endpackage

// ===== design/rc4_dp.sv =====
// rc4_dp: datapath of the rc4 unit: key registers, permutation memory with
// registered read and write forwarding, indices, result register.
// Depends on rc4_pkg; driven by rc4_ctrl commands.
module rc4_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [rc4_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [rc4_pkg::KeyWordW-1:0]  cfg_wdata,
  input  logic [rc4_pkg::DataW-1:0]     in_data_byte,
  input  rc4_pkg::rc4_cmd_t             cmd,
  output rc4_pkg::rc4_stat_t            stat,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [rc4_pkg::DataW-1:0]     out_cipher_byte
);
  import rc4_pkg::*;

  logic [KeyWordW-1:0] key_r [KeyWords];
  logic [DataW-1:0]    mem [TableDepth];
  logic [DataW-1:0]    mem_q_r;
  logic                fwd_hit_r;
  logic [DataW-1:0]    fwd_val_r;

  logic [DataW-1:0] data_r;
  logic [AddrW-1:0] i_r, i_nxt;
  logic [AddrW-1:0] j_r, j_nxt;
  logic [AddrW-1:0] cnt_r, cnt_nxt;
  logic [DataW-1:0] si_r, si_nxt;
  logic             pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [DataW-1:0] out_cipher_r;

  logic             rd_en, wr_en;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic [DataW-1:0] wr_data;
  logic [DataW-1:0] rd_data;
  logic [KeyWordW-1:0] key_sel;
  logic [DataW-1:0] key_byte;
  logic [AddrW-1:0] ks_j, gen_j, t_addr, cnt_inc, i_inc;
  logic [DataW-1:0] ks_val;
  logic             cnt_last;

  // read data, with a same-cycle write to the read address forwarded
  assign rd_data  = fwd_hit_r ? fwd_val_r : mem_q_r;
  assign key_sel  = key_r[cnt_r[3:2]];
  assign key_byte = key_sel[{cnt_r[1:0], 3'b000} +: DataW];
  assign ks_j     = j_r + rd_data + key_byte;
  assign gen_j    = j_r + rd_data;
  assign t_addr   = si_r + rd_data;
  assign cnt_inc  = cnt_r + AddrW'(1);
  assign i_inc    = i_r + AddrW'(1);
  assign cnt_last = (cnt_r == AddrW'(TableDepth - 1));
  // S[j] is still pending when t hits j
  assign ks_val   = pend_r ? si_r : rd_data;

  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = i_inc;
    wr_en    = 1'b0;
    wr_addr  = cnt_r;
    wr_data  = cnt_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    cnt_nxt  = cnt_r;
    si_nxt   = si_r;
    pend_nxt = pend_r;
    if (cmd.rd_next_i) begin
      rd_en   = 1'b1;
      rd_addr = i_inc;
      i_nxt   = i_inc;
    end
    if (cmd.init_wr) begin
      wr_en   = 1'b1;
      wr_addr = cnt_r;
      wr_data = cnt_r;
      cnt_nxt = cnt_inc;
      // key mix starts from j = 0
      j_nxt   = '0;
    end
    if (cmd.ks_rdn) begin
      rd_en   = 1'b1;
      rd_addr = cnt_r;
    end
    if (cmd.ks_rdj) begin
      j_nxt   = ks_j;
      si_nxt  = rd_data;
      rd_en   = 1'b1;
      rd_addr = ks_j;
    end
    if (cmd.ks_wrn) begin
      wr_en   = 1'b1;
      wr_addr = cnt_r;
      wr_data = rd_data;
    end
    if (cmd.ks_wrj) begin
      wr_en   = 1'b1;
      wr_addr = j_r;
      wr_data = si_r;
      rd_en   = 1'b1;
      rd_addr = cnt_inc;
      cnt_nxt = cnt_inc;
      if (cnt_last) begin
        i_nxt = '0;
        j_nxt = '0;
      end
    end
    if (cmd.gen_rj) begin
      si_nxt  = rd_data;
      j_nxt   = gen_j;
      rd_en   = 1'b1;
      rd_addr = gen_j;
    end
    if (cmd.gen_wi) begin
      wr_en    = 1'b1;
      wr_addr  = i_r;
      wr_data  = rd_data;
      rd_en    = 1'b1;
      rd_addr  = t_addr;
      pend_nxt = (t_addr == j_r);
    end
    if (cmd.gen_wj) begin
      wr_en   = 1'b1;
      wr_addr = j_r;
      wr_data = si_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < KeyWords; k++) begin
        key_r[k] <= KeyReset[k];
      end
    end else if (cfg_wr_en) begin
      key_r[cfg_index] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r         <= '0;
      j_r         <= '0;
      cnt_r       <= '0;
      fwd_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (rd_en) begin
        fwd_hit_r <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    si_r   <= si_nxt;
    pend_r <= pend_nxt;
    if (rd_en) begin
      fwd_val_r <= wr_data;
    end
    if (cmd.latch_in) begin
      data_r <= in_data_byte;
    end
    if (cmd.out_load) begin
      out_cipher_r <= data_r ^ ks_val;
    end
  end

  assign stat.cnt_last  = cnt_last;
  assign stat.out_free  = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_cipher_byte = out_cipher_r;

`ifndef SYNTHESIS
  // at most one source drives the single write port
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.init_wr, cmd.ks_wrn, cmd.ks_wrj, cmd.gen_wi, cmd.gen_wj}))
    else $error("rc4_dp: write port conflict");
`endif

endmodule

// ===== design/rc4_ctrl.sv =====
// rc4_ctrl: controller state machine of the rc4 unit; sequences key
// scheduling and keystream generation. Depends on rc4_pkg.
module rc4_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_start_of_message,
  input  rc4_pkg::rc4_stat_t  stat,
  output rc4_pkg::rc4_cmd_t   cmd
);
  import rc4_pkg::*;

  rc4_state_t state_r, state_nxt;
  logic       keyed_r, keyed_nxt;
  logic       ready;
  logic       accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      keyed_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      keyed_r <= keyed_nxt;
    end
  end

  // next byte may come in the cycle its predecessor finishes
  assign ready    = (state_r == ST_IDLE) || ((state_r == ST_GEN_WJ) && stat.out_free);
  assign accept   = in_valid && ready;
  assign in_stall = !ready;

  always_comb begin
    state_nxt = state_r;
    keyed_nxt = keyed_r;
    cmd       = '0;
    if (accept) begin
      cmd.latch_in = 1'b1;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_start_of_message || !keyed_r) begin
            state_nxt = ST_KS_INIT;
          end else begin
            cmd.rd_next_i = 1'b1;
            state_nxt     = ST_GEN_RJ;
          end
        end
      end
      ST_KS_INIT: begin
        cmd.init_wr = 1'b1;
        if (stat.cnt_last) begin
          state_nxt = ST_KS_RDN;
        end
      end
      ST_KS_RDN: begin
        cmd.ks_rdn = 1'b1;
        state_nxt  = ST_KS_RDJ;
      end
      ST_KS_RDJ: begin
        cmd.ks_rdj = 1'b1;
        state_nxt  = ST_KS_WRN;
      end
      ST_KS_WRN: begin
        cmd.ks_wrn = 1'b1;
        state_nxt  = ST_KS_WRJ;
      end
      ST_KS_WRJ: begin
        cmd.ks_wrj = 1'b1;
        if (stat.cnt_last) begin
          keyed_nxt = 1'b1;
          state_nxt = ST_GEN_RI;
        end else begin
          state_nxt = ST_KS_RDJ;
        end
      end
      ST_GEN_RI: begin
        cmd.rd_next_i = 1'b1;
        state_nxt     = ST_GEN_RJ;
      end
      ST_GEN_RJ: begin
        cmd.gen_rj = 1'b1;
        state_nxt  = ST_GEN_WI;
      end
      ST_GEN_WI: begin
        cmd.gen_wi = 1'b1;
        state_nxt  = ST_GEN_WJ;
      end
      ST_GEN_WJ: begin
        cmd.gen_wj = 1'b1;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (accept) begin
            if (in_start_of_message) begin
              state_nxt = ST_KS_INIT;
            end else begin
              cmd.rd_next_i = 1'b1;
              state_nxt     = ST_GEN_RJ;
            end
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // first byte after reset always runs key scheduling
  a_unkeyed_sched: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !keyed_r) |=> (state_r == ST_KS_INIT))
    else $error("rc4_ctrl: unkeyed byte skipped key scheduling");
  a_keyed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    keyed_r |=> keyed_r)
    else $error("rc4_ctrl: keyed flag dropped");
  a_gen_keyed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GEN_RJ) |-> keyed_r)
    else $error("rc4_ctrl: keystream generated before key scheduling");
  a_load_one_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (state_r != ST_GEN_WI) && (state_r != ST_GEN_WJ))
    else $error("rc4_ctrl: result loaded twice for one byte");
`endif

endmodule

// ===== design/rc4_stream_cipher_unit.sv =====
// rc4_stream_cipher_unit: byte-wide rc4 cipher top level.
// A keyed byte runs GEN_RJ, GEN_WI and GEN_WJ after its input transfer; the result register
// loads in GEN_WJ once the output is free, and the next byte can be taken in that state, with
// the rate set by the three dependent reads of the 256x8 table. Key scheduling first does an
// identity fill, then the key mix per entry (two dependent reads, two writes).
// Synchronous active-low reset loads the default key and forces scheduling on the next byte.
module rc4_stream_cipher_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [rc4_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [rc4_pkg::KeyWordW-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rc4_pkg::DataW-1:0]     in_data_byte,
  input  logic                          in_start_of_message,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rc4_pkg::DataW-1:0]     out_cipher_byte
);
  import rc4_pkg::*;

  rc4_cmd_t  cmd;
  rc4_stat_t stat;

  rc4_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_start_of_message (in_start_of_message),
    .stat                (stat),
    .cmd                 (cmd)
  );

  rc4_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_data_byte    (in_data_byte),
    .cmd             (cmd),
    .stat            (stat),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_cipher_byte (out_cipher_byte)
  );

endmodule

// ===== sim/rc4_cipher_checker.sv =====
// rc4_cipher_checker: watches the key write port and both byte channels, keeps its own
// copy of the rc4 state and compares each result transfer with the predicted byte.
// Depends on rc4_pkg for widths and the key reset values.
module rc4_cipher_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [rc4_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rc4_pkg::KeyWordW-1:0] cfg_wdata,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [rc4_pkg::DataW-1:0]    in_data_byte,
  input  logic                         in_start_of_message,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [rc4_pkg::DataW-1:0]    out_cipher_byte,
  output int                           fail_count,
  output int                           pending,
  output int                           bytes_checked,
  output int                           schedules_run
);
  import rc4_pkg::*;

  logic [KeyWordW-1:0] key_reg [KeyWords];
  logic [DataW-1:0]    sbox [TableDepth];
  logic [AddrW-1:0]    idx_i;
  logic [AddrW-1:0]    idx_j;
  logic                keyed;
  logic [DataW-1:0]    cipher_expected [$];
  logic [DataW-1:0]    want;

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR %s", $time, msg);
    fail_count = fail_count + 1;
  endtask

  function automatic void run_key_schedule();
    int n;
    logic [DataW-1:0] jj;
    logic [DataW-1:0] kb;
    logic [DataW-1:0] t;
    for (n = 0; n < TableDepth; n++) sbox[n] = n[7:0];
    jj = '0;
    for (n = 0; n < TableDepth; n++) begin
      kb = key_reg[(n >> 2) & 3][8*(n & 3) +: 8];
      jj = jj + sbox[n] + kb;
      // true swap, so an entry swapped with itself keeps its value
      t        = sbox[n];
      sbox[n]  = sbox[jj];
      sbox[jj] = t;
    end
    idx_i = '0;
    idx_j = '0;
    keyed = 1'b1;
    schedules_run = schedules_run + 1;
  endfunction

  function automatic logic [DataW-1:0] next_keystream_byte();
    logic [DataW-1:0] t;
    idx_i       = idx_i + 8'd1;
    idx_j       = idx_j + sbox[idx_i];
    t           = sbox[idx_i];
    sbox[idx_i] = sbox[idx_j];
    sbox[idx_j] = t;
    t = sbox[idx_i] + sbox[idx_j];
    return sbox[t];
  endfunction

  function automatic logic [DataW-1:0] predict_cipher_byte(input logic [DataW-1:0] d,
                                                           input logic som);
    // an unkeyed block schedules first whatever the start flag says
    if (som || !keyed) run_key_schedule();
    return d ^ next_keystream_byte();
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < KeyWords; k++) key_reg[k] = KeyReset[k];
      idx_i = '0;
      idx_j = '0;
      keyed = 1'b0;
      cipher_expected.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (cipher_expected.size() == 0) begin
          report_mismatch($sformatf("result transfer 0x%02h with nothing expected",
                                    out_cipher_byte));
        end else begin
          want = cipher_expected.pop_front();
          if (out_cipher_byte !== want)
            report_mismatch($sformatf("cipher_byte #%0d: got 0x%02h, expected 0x%02h",
                                      bytes_checked, out_cipher_byte, want));
          bytes_checked = bytes_checked + 1;
        end
      end
      // new key only matters at the next schedule
      if (cfg_wr_en) key_reg[cfg_index] = cfg_wdata;
      if (in_valid && !in_stall)
        cipher_expected.push_back(predict_cipher_byte(in_data_byte, in_start_of_message));
    end
    pending <= cipher_expected.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// tb_top: clock, reset and stimulus for rc4_stream_cipher_unit, with the checker beside it.
// Depends on rc4_pkg, rc4_stream_cipher_unit and rc4_cipher_checker.
module tb_top;
  import rc4_pkg::*;

  localparam int CycleLimit = 10_000_000;
  localparam logic [CfgIdxW-1:0] KeyWord0Idx = 2'd0;
  localparam logic [CfgIdxW-1:0] KeyWord1Idx = 2'd1;
  localparam logic [CfgIdxW-1:0] KeyWord2Idx = 2'd2;
  localparam logic [CfgIdxW-1:0] KeyWord3Idx = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [KeyWordW-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic [DataW-1:0]    in_data_byte;
  logic                in_start_of_message;
  logic                out_valid;
  logic                out_stall;
  logic [DataW-1:0]    out_cipher_byte;

  int fail_count;
  int pending;
  int bytes_checked;
  int schedules_run;
  int burst_left;
  int outs_taken;
  int cycle_count;
  bit hold_done;

  rc4_stream_cipher_unit DUT (.*);
  rc4_cipher_checker cipher_check (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (out_valid && !out_stall) outs_taken <= outs_taken + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
    $display("Mismatches found");
    $finish;
  end

  // receiver: stall pattern changes between random modes, with one long hold-off
  initial begin
    int mode;
    int span;
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      if (!hold_done && outs_taken >= 400) begin
        hold_done = 1'b1;
        @(negedge clk) out_stall <= 1'b1;
        repeat (300) @(negedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(16, 96);
        repeat (span) begin
          @(negedge clk);
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ($urandom_range(0, 15) != 0);
          endcase
        end
      end
    end
  end

  task automatic send_byte(input logic [DataW-1:0] d, input logic som);
    int gap;
    @(negedge clk);
    in_valid            <= 1'b1;
    in_data_byte        <= d;
    in_start_of_message <= som;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // wait until every transfer so far has its result
  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [KeyWordW-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk) cfg_wr_en <= 1'b0;
  endtask

  task automatic write_key(input logic [KeyWordW-1:0] w0, input logic [KeyWordW-1:0] w1,
                           input logic [KeyWordW-1:0] w2, input logic [KeyWordW-1:0] w3);
    write_reg(KeyWord0Idx, w0);
    write_reg(KeyWord1Idx, w1);
    write_reg(KeyWord2Idx, w2);
    write_reg(KeyWord3Idx, w3);
  endtask

  function automatic logic [KeyWordW-1:0] pick_key_word();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed messages, some continued without a restart, some with stray starts
  task automatic random_segment(input int count);
    int sent;
    int len;
    int kind;
    logic som;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      if (kind == 0)      len = $urandom_range(1, 20);
      else if (kind == 1) len = $urandom_range(1, 10);
      else len = ($urandom_range(0, 7) == 0) ? $urandom_range(49, 200) : $urandom_range(1, 48);
      for (int k = 0; k < len; k++) begin
        case (kind)
          0:       som = 1'b0;
          1:       som = ($urandom_range(0, 3) == 0);
          default: som = (k == 0);
        endcase
        send_byte(DataW'($urandom_range(0, 255)), som);
      end
      sent += len;
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    in_valid            = 1'b0;
    in_data_byte        = '0;
    in_start_of_message = 1'b0;
    burst_left          = 1;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // reset key; first byte has no start flag but must still schedule
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);

    // all-zero key gives self swaps during scheduling
    settle();
    write_key('0, '0, '0, '0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);

    settle();
    write_key('1, '1, '1, '1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hC3, 1'b0);

    // key written mid-message: old keystream runs on until the next start
    settle();
    write_key($urandom, $urandom, $urandom, $urandom);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b1);
    send_byte(8'h78, 1'b0);

    for (int seg = 0; seg < 6; seg++) begin
      settle();
      write_key(pick_key_word(), pick_key_word(), pick_key_word(), pick_key_word());
      random_segment(150);
    end

    settle();
    repeat (8) @(posedge clk);
    $display("run covered %0d byte transfers and %0d key schedules", bytes_checked,
             schedules_run);
    $display("keys: reset, all-zero, all-one and random words; one 300-cycle output hold-off");
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
